// ----- sv/srd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg
// shared types, constants and the byte-wise crc-8 function of the decoder
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [15:0] READY_MASK  = 16'h07FF;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] RH_SCALE    = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_CRC       = 2'd2,
    ST_BUS       = 2'd3
  } srd_status_t;

  // one finished transaction, raw words, waiting for conversion
  typedef struct packed {
    srd_status_t status;
    logic [15:0] co2_word;
    logic [15:0] temp_word;
    logic [15:0] rh_word;
  } srd_result_t;

  typedef struct packed {
    logic        valid;
    srd_result_t result;
  } srd_push_t;

  // msb-first crc-8, one byte, no reflection
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/srd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_front
// frame tracker: byte position, running crc, word capture, result push
// ----------------------------------------------------------------------------
module srd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             start_req,
  input  logic [7:0]       rx_byte,
  input  logic             bus_error,
  output srd_pkg::srd_push_t push
);
  import srd_pkg::*;

  localparam logic [3:0] P_RDY_H  = 4'd0;
  localparam logic [3:0] P_RDY_L  = 4'd1;
  localparam logic [3:0] P_RDY_C  = 4'd2;
  localparam logic [3:0] P_CO2_H  = 4'd3;
  localparam logic [3:0] P_CO2_L  = 4'd4;
  localparam logic [3:0] P_CO2_C  = 4'd5;
  localparam logic [3:0] P_TEMP_H = 4'd6;
  localparam logic [3:0] P_TEMP_L = 4'd7;
  localparam logic [3:0] P_TEMP_C = 4'd8;
  localparam logic [3:0] P_RH_H   = 4'd9;
  localparam logic [3:0] P_RH_L   = 4'd10;
  localparam logic [3:0] P_RH_C   = 4'd11;

  logic        active, active_next;
  logic [3:0]  pos, pos_next;
  logic [7:0]  crc, crc_next;
  logic [7:0]  word_high, word_high_next;
  logic [7:0]  word_low, word_low_next;
  logic [15:0] co2_word, co2_word_next;
  logic [15:0] temp_word, temp_word_next;

  logic        eff_active;
  logic [3:0]  eff_pos;
  logic [7:0]  eff_crc;
  logic        is_high;
  logic [7:0]  crc_in;
  logic [7:0]  crc_step;
  logic [15:0] word;

  assign eff_active = start_req | active;
  assign eff_pos    = start_req ? 4'd0 : pos;
  assign eff_crc    = start_req ? CRC_INIT : crc;
  assign is_high    = (eff_pos == P_RDY_H) || (eff_pos == P_CO2_H) ||
                      (eff_pos == P_TEMP_H) || (eff_pos == P_RH_H);
  assign crc_in     = is_high ? CRC_INIT : eff_crc;
  assign crc_step   = crc_update(crc_in, rx_byte);
  assign word       = {word_high, word_low};

  always_comb begin
    active_next    = active;
    pos_next       = pos;
    crc_next       = crc;
    word_high_next = word_high;
    word_low_next  = word_low;
    co2_word_next  = co2_word;
    temp_word_next = temp_word;
    push           = '0;
    push.result.status = ST_OK;

    if (accept && eff_active) begin
      active_next = 1'b1;
      pos_next    = eff_pos;
      crc_next    = eff_crc;
      if (bus_error) begin
        push.valid         = 1'b1;
        push.result.status = ST_BUS;
        active_next        = 1'b0;
        pos_next           = 4'd0;
        crc_next           = CRC_INIT;
      end else begin
        case (eff_pos) inside
          P_RDY_H, P_CO2_H, P_TEMP_H, P_RH_H: begin
            word_high_next = rx_byte;
            crc_next       = crc_step;
            pos_next       = eff_pos + 4'd1;
          end
          P_RDY_L, P_CO2_L, P_TEMP_L, P_RH_L: begin
            word_low_next = rx_byte;
            crc_next      = crc_step;
            pos_next      = eff_pos + 4'd1;
          end
          P_RDY_C, P_CO2_C, P_TEMP_C, P_RH_C: begin
            if (eff_crc != rx_byte) begin
              push.valid         = 1'b1;
              push.result.status = ST_CRC;
              active_next        = 1'b0;
              pos_next           = 4'd0;
              crc_next           = CRC_INIT;
            end else begin
              crc_next = CRC_INIT;
              pos_next = eff_pos + 4'd1;
              case (eff_pos)
                P_RDY_C: begin
                  if ((word & READY_MASK) == 16'd0) begin
                    push.valid         = 1'b1;
                    push.result.status = ST_NOT_READY;
                    active_next        = 1'b0;
                    pos_next           = 4'd0;
                  end
                end
                P_CO2_C:  co2_word_next  = word;
                P_TEMP_C: temp_word_next = word;
                default: begin
                  // humidity word closes a good block
                  push.valid              = 1'b1;
                  push.result.status      = ST_OK;
                  push.result.co2_word    = co2_word;
                  push.result.temp_word   = temp_word;
                  push.result.rh_word     = word;
                  active_next             = 1'b0;
                  pos_next                = 4'd0;
                end
              endcase
            end
          end
          default: begin
            // position past the block, drop silently
            active_next = 1'b0;
            pos_next    = 4'd0;
            crc_next    = CRC_INIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= 4'd0;
      crc    <= CRC_INIT;
    end else begin
      active <= active_next;
      pos    <= pos_next;
      crc    <= crc_next;
    end
    word_high <= word_high_next;
    word_low  <= word_low_next;
    co2_word  <= co2_word_next;
    temp_word <= temp_word_next;
  end

endmodule

// ----- sv/srd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_queue
// small fifo of finished transactions between tracker and converter
// ----------------------------------------------------------------------------
module srd_queue #(
  parameter int QDEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srd_pkg::srd_push_t    push,
  input  logic                  pop,
  output srd_pkg::srd_result_t  head,
  output logic                  full,
  output logic                  empty
);
  import srd_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QDEPTH);

  srd_result_t   entries [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/srd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_back
// converter: scales raw words and holds the result in the output register
// ----------------------------------------------------------------------------
module srd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  srd_pkg::srd_result_t head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [15:0]          co2_ppm,
  output logic signed [14:0]   temp_centi,
  output logic [13:0]          rh_x100
);
  import srd_pkg::*;

  logic [30:0] temp_prod;
  logic [29:0] rh_prod;
  logic [14:0] temp_val;
  logic        is_ok;

  assign pop       = head_valid && (!out_valid || out_ready);
  assign is_ok     = (head.status == ST_OK);
  assign temp_prod = 31'(TEMP_SCALE) * 31'(head.temp_word);
  assign rh_prod   = 30'(RH_SCALE) * 30'(head.rh_word);
  // result lies in -4500..12999, so 15-bit wraparound gives the signed value
  assign temp_val  = temp_prod[30:16] - TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      status     <= head.status;
      co2_ppm    <= is_ok ? head.co2_word : 16'd0;
      temp_centi <= is_ok ? $signed(temp_val) : 15'sd0;
      rh_x100    <= is_ok ? rh_prod[29:16] : 14'd0;
    end
  end

endmodule

// ----- sv/sensor_response_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_response_decoder
// decodes the byte stream of one sensor read transaction into a result item
// ----------------------------------------------------------------------------
// throughput: one byte item per cycle; in_ready drops only while the result
//   queue is full (output register stalled with QDEPTH more results queued)
// result path: the byte item that closes the transaction pushes its result into the
//   queue, and the result moves on into the output register once that is free
// reset: synchronous, active high; clears frame tracking, queue pointers and
//   output valid, so the block comes out of reset idle and ready
// ----------------------------------------------------------------------------
module sensor_response_decoder #(
  parameter int QDEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  // byte input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                start_req,
  input  logic [7:0]          rx_byte,
  input  logic                bus_error,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [15:0]         co2_ppm,
  output logic signed [14:0]  temp_centi,
  output logic [13:0]         rh_x100
);
  import srd_pkg::*;

  srd_push_t   push;
  srd_result_t head;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  logic        accept;

  // the tracker only ever pushes on an accepted byte, and a byte is only
  // accepted while the queue has room, so no push is ever dropped
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: byte position, crc check, word capture, classification
  srd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .start_req (start_req),
    .rx_byte   (rx_byte),
    .bus_error (bus_error),
    .push      (push)
  );

  // decouples the tracker from a stalled output
  srd_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: constant-scale conversion into the output register
  srd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .co2_ppm    (co2_ppm),
    .temp_centi (temp_centi),
    .rh_x100    (rh_x100)
  );

endmodule

// ----- sv/srd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
module srd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [15:0]        co2_ppm,
  input logic signed [14:0] temp_centi,
  input logic [13:0]        rh_x100
);
  import srd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(co2_ppm) &&
      $stable(temp_centi) && $stable(rh_x100))
    else $error("stalled result changed");

  // failed transactions carry zeroed values
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> co2_ppm == 16'd0 && temp_centi == 15'sd0 &&
      rh_x100 == 14'd0)
    else $error("non-ok result with nonzero values");

  // converted values stay in their scaled ranges
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> temp_centi >= -15'sd4500 &&
      temp_centi <= 15'sd12999 && rh_x100 <= 14'd9999)
    else $error("converted value out of range");

  // reset empties the output and the queue
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state left after reset");

endmodule

bind sensor_response_decoder srd_checker u_srd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .co2_ppm    (co2_ppm),
  .temp_centi (temp_centi),
  .rh_x100    (rh_x100)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sensor response decoder against a cycle-free decoding model:
// a short table of hand-picked byte items, then random read transactions
// with crc faults, bus errors and cut-off frames, with random idling on both
// channels and one long output stall that backs the block up
// ----------------------------------------------------------------------------
module testbench;
  import srd_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_PCT     = 32;    // idle cycles per hundred, each side
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 400;   // long output stall
  localparam int HOLD_AT      = 300;   // counted random items before the stall
  localparam int CALM_FROM    = 700;   // window with no idling at all
  localparam int CALM_TO      = 900;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_ROWS     = 25;

  // conversion constants of the result fields
  localparam logic [31:0] TEMP_SPAN  = 32'd17500;
  localparam logic [31:0] RH_SPAN    = 32'd10000;
  localparam int          TEMP_FLOOR = -4500;

  // one decoded result item
  typedef struct packed {
    srd_status_t        status;
    logic [15:0]        co2;
    logic signed [14:0] temp;
    logic [13:0]        rh;
  } reading_t;

  // how the byte of a table row is formed
  typedef enum logic [1:0] {
    BK_DATA,     // value as written
    BK_CRC_OK,   // the crc of the word so far
    BK_CRC_BAD   // a corrupted crc
  } byte_kind_t;

  // where the expectation of a table row comes from
  typedef enum logic [1:0] {
    EXP_MODEL,   // from the decoding model
    EXP_NONE,    // no result at all
    EXP_TYPED    // the result written in the row
  } exp_kind_t;

  typedef struct packed {
    logic       start;
    byte_kind_t kind;
    logic [7:0] value;
    logic       berr;
    exp_kind_t  chk;
    reading_t   want;
  } stim_row_t;

  localparam reading_t NO_READING = '{ST_OK, 16'h0000, 15'sd0, 14'd0};
  localparam reading_t R_BUS      = '{ST_BUS, 16'h0000, 15'sd0, 14'd0};
  localparam reading_t R_CRC      = '{ST_CRC, 16'h0000, 15'sd0, 14'd0};
  localparam reading_t R_NOTRDY   = '{ST_NOT_READY, 16'h0000, 15'sd0, 14'd0};
  localparam reading_t R_EXTREME  = '{ST_OK, 16'hFFFF, -15'sd4500, 14'd9999};

  // clock, reset and block ports; the driven ones are known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               start_req = 1'b0;
  logic [7:0]         rx_byte = 8'h00;
  logic               bus_error = 1'b0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         status;
  logic [15:0]        co2_ppm;
  logic signed [14:0] temp_centi;
  logic [13:0]        rh_x100;

  // decoding model state
  logic [3:0]  frame_pos;
  logic        in_frame;
  logic [7:0]  crc_acc;
  logic [7:0]  word_hi;
  logic [7:0]  word_lo;
  logic [15:0] co2_held;
  logic [15:0] temp_held;

  reading_t readings_due[$];   // results still to come, oldest first
  int       counted_items;     // items that the decoder did not ignore
  int       mismatches = 0;
  int       stall_cycles = 0;
  bit       calm = 1'b0;       // no idling on either side
  bit       hold_go = 1'b0;    // asks the output side for its long stall

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sensor_response_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_req  (start_req),
    .rx_byte    (rx_byte),
    .bus_error  (bus_error),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .co2_ppm    (co2_ppm),
    .temp_centi (temp_centi),
    .rh_x100    (rh_x100)
  );

  // crc-8, poly 0x31, fed one data bit at a time, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // random word, with the two extremes showing up often
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drop_frame();
    in_frame  = 1'b0;
    frame_pos = 4'd0;
    crc_acc   = CRC_INIT;
  endtask

  task automatic model_reset();
    drop_frame();
    word_hi   = 8'h00;
    word_lo   = 8'h00;
    co2_held  = 16'h0000;
    temp_held = 16'h0000;
  endtask

  // advances the decoding model by one accepted byte item
  task automatic decode_byte(input logic s, input logic [7:0] b, input logic e,
                             output logic got, output reading_t r);
    logic [15:0] word;
    logic [31:0] t_prod;
    logic [31:0] h_prod;
    int          t_val;
    got = 1'b0;
    r   = NO_READING;
    // a start always opens a fresh frame, dropping any frame in flight
    if (s) begin
      in_frame  = 1'b1;
      frame_pos = 4'd0;
      crc_acc   = CRC_INIT;
    end
    if (!in_frame) begin
      return;
    end
    if (e) begin
      r.status = ST_BUS;
      got      = 1'b1;
      drop_frame();
      return;
    end
    if (frame_pos > 4'd11) begin
      drop_frame();
      return;
    end
    case (frame_pos % 3)
      0: begin
        word_hi   = b;
        crc_acc   = crc8_step(CRC_INIT, b);
        frame_pos = frame_pos + 4'd1;
      end
      1: begin
        word_lo   = b;
        crc_acc   = crc8_step(crc_acc, b);
        frame_pos = frame_pos + 4'd1;
      end
      default: begin
        if (crc_acc != b) begin
          r.status = ST_CRC;
          got      = 1'b1;
          drop_frame();
          return;
        end
        word    = {word_hi, word_lo};
        crc_acc = CRC_INIT;
        case (frame_pos)
          4'd2: begin
            // ready word with no data-ready bits set
            if ((word & READY_MASK) == 16'h0000) begin
              r.status = ST_NOT_READY;
              got      = 1'b1;
              drop_frame();
              return;
            end
          end
          4'd5: co2_held = word;
          4'd8: temp_held = word;
          default: begin
            t_prod   = TEMP_SPAN * {16'd0, temp_held};
            h_prod   = RH_SPAN * {16'd0, word};
            t_val    = TEMP_FLOOR + int'(t_prod >> 16);
            r.status = ST_OK;
            r.co2    = co2_held;
            r.temp   = t_val[14:0];
            r.rh     = h_prod[29:16];
            got      = 1'b1;
            drop_frame();
            return;
          end
        endcase
        frame_pos = frame_pos + 4'd1;
      end
    endcase
  endtask

  // offers one byte item, waits for it to be taken, records what it should cause
  task automatic send_byte(input logic s, input byte_kind_t kind, input logic [7:0] value,
                           input logic e, input exp_kind_t chk, input reading_t want);
    logic [7:0] b;
    logic       got;
    logic       counts;
    reading_t   r;
    case (kind)
      BK_CRC_OK:  b = crc_acc;
      BK_CRC_BAD: b = crc_acc ^ 8'($urandom_range(1, 255));
      default:    b = value;
    endcase
    in_valid  <= 1'b1;
    start_req <= s;
    rx_byte   <= b;
    bus_error <= e;
    do @(posedge clk); while (!in_ready);
    counts = s || in_frame;
    decode_byte(s, b, e, got, r);
    if (counts) begin
      counted_items++;
    end
    case (chk)
      EXP_MODEL: if (got) readings_due.push_back(r);
      EXP_TYPED: readings_due.push_back(want);
      default: ;
    endcase
    // random gap before the next item, any length, at any frame position
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // one random transaction: mostly well formed, sometimes broken or just noise
  task automatic send_frame();
    logic [15:0] words[4];
    logic [7:0]  b;
    logic        e;
    byte_kind_t  kind;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // fully random item
      send_byte(1'($urandom), BK_DATA, 8'($urandom), 1'($urandom), EXP_MODEL, NO_READING);
      return;
    end
    if (pick < 14) begin
      // stray byte without start: ignored when idle, joins a cut-off frame otherwise
      send_byte(1'b0, BK_DATA, 8'($urandom), 1'($urandom), EXP_MODEL, NO_READING);
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      words[0] = {5'($urandom), 11'd0};
    end else begin
      words[0] = pick_word();
      if ((words[0] & READY_MASK) == 16'h0000) begin
        words[0][0] = 1'b1;
      end
    end
    for (int w = 1; w < 4; w++) begin
      words[w] = pick_word();
    end
    for (int p = 0; p < 12; p++) begin
      e    = 1'b0;
      kind = BK_DATA;
      b    = 8'h00;
      pick = $urandom_range(0, 199);
      if (pick < 2) begin
        e = 1'b1;
      end else if (pick < 4) begin
        // cut the frame short, the next start drops it
        break;
      end
      case (p % 3)
        0: b = words[p / 3][15:8];
        1: b = words[p / 3][7:0];
        default: kind = (pick < 8) ? BK_CRC_BAD : BK_CRC_OK;
      endcase
      send_byte(p == 0, kind, b, e, EXP_MODEL, NO_READING);
      if (!in_frame) begin
        break;
      end
    end
  endtask

  // input side: directed table, then random transactions, then the drain
  initial begin
    stim_row_t rows[NUM_ROWS];
    rows = '{
      // bus error on an idle byte is ignored
      '{1'b0, BK_DATA,    8'hA5, 1'b1, EXP_NONE,  NO_READING},
      // start together with a bus error
      '{1'b1, BK_DATA,    8'hFF, 1'b1, EXP_TYPED, R_BUS},
      // ready word with no data-ready bits: not ready
      '{1'b1, BK_DATA,    8'hF8, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_OK,  8'h00, 1'b0, EXP_TYPED, R_NOTRDY},
      // ready word with a corrupted crc
      '{1'b1, BK_DATA,    8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'h01, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_BAD, 8'h00, 1'b0, EXP_TYPED, R_CRC},
      // good frame: all ready bits, co2 max, temperature min, humidity max
      '{1'b1, BK_DATA,    8'h07, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'hFF, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_OK,  8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'hFF, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'hFF, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_OK,  8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_OK,  8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'hFF, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'hFF, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_OK,  8'h00, 1'b0, EXP_TYPED, R_EXTREME},
      // start inside a running frame, then a bus error mid-block
      '{1'b1, BK_DATA,    8'h12, 1'b0, EXP_MODEL, NO_READING},
      '{1'b1, BK_DATA,    8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'h01, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_CRC_OK,  8'h00, 1'b0, EXP_MODEL, NO_READING},
      '{1'b0, BK_DATA,    8'h3C, 1'b1, EXP_TYPED, R_BUS}
    };
    model_reset();
    counted_items = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_byte(rows[i].start, rows[i].kind, rows[i].value, rows[i].berr,
                rows[i].chk, rows[i].want);
    end
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (counted_items >= HOLD_AT) begin
        hold_go = 1'b1;
      end
      calm = (counted_items >= CALM_FROM) && (counted_items < CALM_TO);
      send_frame();
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (readings_due.size() != 0) begin
      @(posedge clk);
    end
    // a few more cycles so a stray result would still be caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off, a calm window
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  // compare every taken result item with the oldest one due
  always @(posedge clk) begin : check_results
    reading_t due;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: status %0d co2 %0d temp %0d rh %0d",
                   status, co2_ppm, temp_centi, rh_x100);
        end
      end else begin
        due = readings_due.pop_front();
        if (status !== due.status || co2_ppm !== due.co2 ||
            temp_centi !== due.temp || rh_x100 !== due.rh) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected status %0d co2 %0d temp %0d rh %0d",
                     due.status, due.co2, due.temp, due.rh);
            $display("          actual   status %0d co2 %0d temp %0d rh %0d",
                     status, co2_ppm, temp_centi, rh_x100);
          end
        end
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

// ----- sensor_response_decoder.f -----
sv/srd_pkg.sv
sv/srd_front.sv
sv/srd_queue.sv
sv/srd_back.sv
sv/sensor_response_decoder.sv
sv/srd_checker.sv
sim/testbench.sv
